@@ src/pce_pkg.sv @@
// ----------------------------------------------------------------------------
// pce_pkg: shared types and the scan code table for the pad change to scancode block
// Holds the request and event payload types and the fixed AT scan code table.
// ----------------------------------------------------------------------------
package pce_pkg;

  // Fixed field widths.
  localparam int unsigned ButtonW   = 4;
  localparam int unsigned PadFieldW = 5;
  localparam int unsigned CodeW     = 7;
  localparam int unsigned CountW    = 3;

  // Table shape and parameter defaults.
  localparam int unsigned TablePads    = 5;
  localparam int unsigned TableButtons = 12;
  localparam int unsigned DefButtonSlots = 12;
  localparam int unsigned DefMaxPads     = 5;
  localparam logic [CountW-1:0] PadCountReset = 3'd1;

  // Incoming request: one sampled button slot across all pads.
  typedef struct packed {
    logic [ButtonW-1:0]   button_index;
    logic [PadFieldW-1:0] pad_bits;
  } pce_in_t;

  // Outgoing key event.
  typedef struct packed {
    logic [CodeW-1:0] scan_code;
    logic             released;
    logic             last;
  } pce_out_t;

  // AT set-1 make codes, one row per pad, one column per button slot.
  localparam logic [CodeW-1:0] CodeTable [TablePads][TableButtons] = '{
    '{7'h30, 7'h15, 7'h19, 7'h18, 7'h10, 7'h11, 7'h12, 7'h16, 7'h1e, 7'h2d, 7'h26, 7'h13},
    '{7'h2c, 7'h2e, 7'h1f, 7'h1c, 7'h48, 7'h50, 7'h4b, 7'h4d, 7'h4e, 7'h52, 7'h02, 7'h03},
    '{7'h14, 7'h15, 7'h16, 7'h17, 7'h18, 7'h1a, 7'h1b, 7'h2b, 7'h20, 7'h21, 7'h22, 7'h23},
    '{7'h04, 7'h05, 7'h06, 7'h07, 7'h08, 7'h09, 7'h0a, 7'h0b, 7'h0c, 7'h0d, 7'h0e, 7'h24},
    '{7'h3b, 7'h3c, 7'h3d, 7'h3e, 7'h3f, 7'h40, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46}
  };

  // Looks up the make code; positions outside the table read as zero.
  function automatic logic [CodeW-1:0] code_lookup(logic [CountW-1:0] pad,
                                                   logic [ButtonW-1:0] button);
    logic [CodeW-1:0] code;
    code = '0;
    if (32'(pad) < TablePads && 32'(button) < TableButtons) begin
      code = CodeTable[pad][button];
    end
    return code;
  endfunction

endpackage

@@ src/pad_change_to_scancode_events.sv @@
// ----------------------------------------------------------------------------
// pad_change_to_scancode_events: gamepad button changes to AT key events
// Compares each sampled button slot with its last sample and emits one
// make or break event per enabled pad whose button changed.
// ----------------------------------------------------------------------------
// When a request is taken, the slot's stored bits are read and compared.
// The changed-pad mask then shifts out one pad per cycle while the output
// register has room, and each changed pad loads one event into the output
// register. The block stays busy until the highest changed pad has been
// shifted out, and any stall of the output holds it busy longer.
// A request that causes no events (first sample of a slot, no change, slot
// out of range) does not make the block busy. The output register lets the last
// event wait while the next request is accepted.
module pad_change_to_scancode_events #(
  parameter int unsigned BUTTON_SLOTS = pce_pkg::DefButtonSlots,
  parameter int unsigned MAX_PADS     = pce_pkg::DefMaxPads
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pce_pkg::pce_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pce_pkg::pce_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pce_pkg::CountW-1:0]    cfg_data_i
);

  localparam int unsigned SlotW = (BUTTON_SLOTS > 1) ? $clog2(BUTTON_SLOTS) : 1;
  localparam int unsigned PadW  = (MAX_PADS > 1) ? $clog2(MAX_PADS) : 1;

  // Configuration register.
  logic [pce_pkg::CountW-1:0] pad_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_count_q <= pce_pkg::PadCountReset;
    end else if (cfg_valid_i) begin
      pad_count_q <= cfg_data_i;
    end
  end

  // Per-slot state.
  logic [MAX_PADS-1:0]     prev_bits_q [BUTTON_SLOTS];
  logic [BUTTON_SLOTS-1:0] primed_q;

  // Serial engine state.
  logic                       busy_q;
  logic [MAX_PADS-1:0]        chg_q;
  logic [MAX_PADS-1:0]        bits_q;
  logic [PadW-1:0]            pad_q;
  logic [pce_pkg::ButtonW-1:0] slot_q;

  // Request decode.
  logic                in_fire;
  logic                slot_ok;
  logic [SlotW-1:0]    slot_idx;
  logic [MAX_PADS-1:0] new_bits;
  logic [MAX_PADS-1:0] en_mask;
  logic [MAX_PADS-1:0] chg_new;

  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_ok    = (32'(in_data_i.button_index) < BUTTON_SLOTS) &&
                      (32'(in_data_i.button_index) < pce_pkg::TableButtons);
  assign slot_idx   = in_data_i.button_index[SlotW-1:0];
  assign new_bits   = in_data_i.pad_bits[MAX_PADS-1:0];

  // Pad k is enabled when the pad count exceeds k.
  always_comb begin
    for (int k = 0; k < MAX_PADS; k++) begin
      en_mask[k] = (pad_count_q > pce_pkg::CountW'(k));
    end
  end

  assign chg_new = (prev_bits_q[slot_idx] ^ new_bits) & en_mask;

  // Stored bits and primed flags; the stored bits need no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire && slot_ok) begin
      prev_bits_q[slot_idx] <= new_bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= '0;
    end else if (in_fire && slot_ok) begin
      primed_q[slot_idx] <= 1'b1;
    end
  end

  // Output register handshake.
  logic              out_valid_q;
  pce_pkg::pce_out_t out_data_q;
  logic              out_free;
  logic              emit;
  logic [MAX_PADS-1:0] chg_rest;

  assign out_free = !out_valid_q || out_ready_i;
  assign chg_rest = chg_q >> 1;
  assign emit     = busy_q && out_free && chg_q[0];

  // Serial engine: one pad position per cycle while the output has room.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chg_q  <= '0;
      pad_q  <= '0;
    end else if (in_fire) begin
      busy_q <= slot_ok && primed_q[slot_idx] && (chg_new != '0);
      chg_q  <= chg_new;
      pad_q  <= '0;
    end else if (busy_q && out_free) begin
      busy_q <= (chg_rest != '0);
      chg_q  <= chg_rest;
      pad_q  <= pad_q + 1'b1;
    end
  end

  // Payload side of the engine.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bits_q <= new_bits;
      slot_q <= in_data_i.button_index;
    end else if (busy_q && out_free) begin
      bits_q <= bits_q >> 1;
    end
  end

  // Event output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.scan_code <= pce_pkg::code_lookup(pce_pkg::CountW'(pad_q), slot_q);
      out_data_q.released  <= bits_q[0];
      out_data_q.last      <= (chg_rest == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ src/pce_checker.sv @@
// ----------------------------------------------------------------------------
// pce_checker: port-level checks for the pad change to scancode block
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module pce_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input pce_pkg::pce_in_t           in_data_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input pce_pkg::pce_out_t          out_data_o,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic [pce_pkg::CountW-1:0] cfg_data_i
);

  // A stalled event keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled event changed");

  // Every table entry is nonzero, so an event never carries a zero code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.scan_code != '0)
    else $error("event with zero scan code");

  // An event is loaded by the serial engine, never by the request itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("event appeared directly after its request");

  // The configuration register always takes a write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind pad_change_to_scancode_events pce_checker u_pce_checker (.*);
